// ----- src/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    // List depth and derived widths
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    // compare width: room for either operand plus a carry
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_RSP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch command, issue first memory read
        logic shift_up;  // move one entry up, read the next lower one
        logic shift_dn;  // move one entry down, read the next higher one
        logic put;       // write the insert value at its slot
        logic cnt_clr;
        logic cnt_inc;
        logic cnt_dec;
        logic load_out;  // capture the result into the output register
    } dp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t in_cmd;
        logic in_err;      // incoming command fails its bounds check
        logic in_at_end;   // insert position equals count
        logic in_del_last; // delete index is the last entry
        logic up_last;     // current upward move is the final one
        logic dn_last;     // current downward move is the final one
        logic out_free;    // output register can take a result
    } dp_sts_t;

endpackage

// ----- src/positional_insert_delete_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready, cmd, value, position) takes one
//   command per transfer: insert, delete, read or clear. Every command gives
//   exactly one response on the response channel (rsp_valid/rsp_ready,
//   read_value, count, status). Bad commands (insert into a full list,
//   position past the end) come back with an error status and leave the list
//   untouched.
// Throughput:
//   Entries live in a single-port-write, single-port-read memory, so moving
//   entries is a sweep of one entry per cycle. Read, clear, errors and delete
//   of the last entry need no sweep; insert moves the entries from position
//   up and delete those above position. The next command is taken once the
//   sweep is done and its result sits in the output register.
// Reset:
//   The list comes up empty (count zero) with no response pending; the memory
//   contents are not cleared, entries above count are never returned.
// Stall:
//   A pending response holds steady while rsp_ready is low; the block takes
//   one more command in the meantime and waits to deliver it.
// ----------------------------------------------------------------------------
module positional_insert_delete_list (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    input  logic [7:0]          position,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic signed [31:0]  read_value,
    output logic [7:0]          count,
    output logic [1:0]          status
);

    pidl_pkg::dp_ctl_t ctl;
    pidl_pkg::dp_sts_t sts;

    // sequencer
    pidl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // storage, bounds checks and response register
    pidl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .ctl        (ctl),
        .sts        (sts),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

endmodule

// ----- src/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl
// Sequencer: accepts a command, steps the shift sweep, hands off the result.
// ----------------------------------------------------------------------------
module pidl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pidl_pkg::dp_sts_t sts,
    output pidl_pkg::dp_ctl_t ctl
);

    pidl_pkg::state_t state_reg;
    pidl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidl_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (sts.in_err || sts.in_cmd == pidl_pkg::CMD_READ
                        || sts.in_cmd == pidl_pkg::CMD_CLEAR)
                    begin
                        state_next = pidl_pkg::S_RSP;
                    end
                    else if (sts.in_cmd == pidl_pkg::CMD_INSERT)
                    begin
                        state_next = sts.in_at_end ? pidl_pkg::S_PUT
                                                   : pidl_pkg::S_SHIFT_UP;
                    end
                    else
                    begin
                        state_next = sts.in_del_last ? pidl_pkg::S_RSP
                                                     : pidl_pkg::S_SHIFT_DN;
                    end
                end
            end
            pidl_pkg::S_SHIFT_UP:
            begin
                if (sts.up_last)
                begin
                    state_next = pidl_pkg::S_PUT;
                end
            end
            pidl_pkg::S_PUT:
            begin
                state_next = pidl_pkg::S_RSP;
            end
            pidl_pkg::S_SHIFT_DN:
            begin
                if (sts.dn_last)
                begin
                    state_next = pidl_pkg::S_RSP;
                end
            end
            pidl_pkg::S_RSP:
            begin
                if (sts.out_free)
                begin
                    state_next = pidl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pidl_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            pidl_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.start = 1'b1;
                    if (!sts.in_err)
                    begin
                        ctl.cnt_clr = (sts.in_cmd == pidl_pkg::CMD_CLEAR);
                        ctl.cnt_dec = (sts.in_cmd == pidl_pkg::CMD_DELETE)
                                      && sts.in_del_last;
                    end
                end
            end
            pidl_pkg::S_SHIFT_UP:
            begin
                ctl.shift_up = 1'b1;
            end
            pidl_pkg::S_PUT:
            begin
                ctl.put     = 1'b1;
                ctl.cnt_inc = 1'b1;
            end
            pidl_pkg::S_SHIFT_DN:
            begin
                ctl.shift_dn = 1'b1;
                ctl.cnt_dec  = sts.dn_last;
            end
            pidl_pkg::S_RSP:
            begin
                ctl.load_out = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ----- src/pidl_dp.sv -----
// ----------------------------------------------------------------------------
// pidl_dp
// Entry memory, fill count, sweep pointer, bounds checks and output register.
// ----------------------------------------------------------------------------
module pidl_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 cmd,
    input  logic signed [31:0]         value,
    input  logic [7:0]                 position,
    input  pidl_pkg::dp_ctl_t          ctl,
    output pidl_pkg::dp_sts_t          sts,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic signed [31:0]         read_value,
    output logic [7:0]                 count,
    output logic [1:0]                 status
);

    localparam int AW = pidl_pkg::ADDR_W;
    localparam int CW = pidl_pkg::CNT_W;
    localparam int MW = pidl_pkg::CMP_W;

    logic [pidl_pkg::DATA_W-1:0] mem [pidl_pkg::CAPACITY];
    logic [pidl_pkg::DATA_W-1:0] rdata_reg;

    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic [CW-1:0]               ptr_reg;
    logic [CW-1:0]               ptr_next;
    logic [pidl_pkg::POS_W-1:0]  pos_reg;
    logic [pidl_pkg::DATA_W-1:0] val_reg;
    pidl_pkg::cmd_t              cmd_reg;
    pidl_pkg::status_t           st_reg;

    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic [pidl_pkg::DATA_W-1:0] rv_reg;
    logic [7:0]                  cnt_out_reg;
    pidl_pkg::status_t           st_out_reg;

    logic [MW-1:0]               pos_x;
    logic [MW-1:0]               cnt_x;
    pidl_pkg::cmd_t              cmd_in;
    pidl_pkg::status_t           st_in;

    logic                        re;
    logic [AW-1:0]               raddr;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [pidl_pkg::DATA_W-1:0] wdata;

    assign cmd_in = pidl_pkg::cmd_t'(cmd);
    assign pos_x  = MW'(position);
    assign cnt_x  = MW'(cnt_reg);

    // bounds check on the incoming command
    always_comb
    begin
        st_in = pidl_pkg::ST_DONE;
        case (cmd_in)
            pidl_pkg::CMD_INSERT:
            begin
                if (cnt_x >= MW'(pidl_pkg::CAPACITY))
                begin
                    st_in = pidl_pkg::ST_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    st_in = pidl_pkg::ST_RANGE;
                end
            end
            pidl_pkg::CMD_DELETE, pidl_pkg::CMD_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    st_in = pidl_pkg::ST_RANGE;
                end
            end
            default:
            begin
                st_in = pidl_pkg::ST_DONE;
            end
        endcase
    end

    assign sts.in_cmd      = cmd_in;
    assign sts.in_err      = (st_in != pidl_pkg::ST_DONE);
    assign sts.in_at_end   = (pos_x == cnt_x);
    assign sts.in_del_last = (pos_x + MW'(1) == cnt_x);
    assign sts.up_last     = (MW'(ptr_reg) == MW'(pos_reg) + MW'(1));
    assign sts.dn_last     = (MW'(ptr_reg) + MW'(2) == cnt_x);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    // memory port control
    always_comb
    begin
        re       = 1'b0;
        raddr    = '0;
        we       = 1'b0;
        waddr    = AW'(ptr_reg);
        wdata    = rdata_reg;
        ptr_next = ptr_reg;
        if (ctl.start)
        begin
            re = 1'b1;
            case (cmd_in)
                pidl_pkg::CMD_INSERT:
                begin
                    raddr    = AW'(cnt_reg - CW'(1));
                    ptr_next = cnt_reg;
                end
                pidl_pkg::CMD_DELETE:
                begin
                    raddr    = AW'(position + 8'd1);
                    ptr_next = CW'(position);
                end
                default:
                begin
                    raddr = AW'(position);
                end
            endcase
        end
        else if (ctl.shift_up)
        begin
            we       = 1'b1;
            re       = 1'b1;
            raddr    = AW'(ptr_reg - CW'(2));
            ptr_next = ptr_reg - CW'(1);
        end
        else if (ctl.shift_dn)
        begin
            we       = 1'b1;
            re       = 1'b1;
            raddr    = AW'(ptr_reg + CW'(2));
            ptr_next = ptr_reg + CW'(1);
        end
        else if (ctl.put)
        begin
            we    = 1'b1;
            wdata = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (ctl.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    assign rsp_valid_next = ctl.load_out || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.start)
        begin
            pos_reg <= position;
            val_reg <= value;
            cmd_reg <= cmd_in;
            st_reg  <= st_in;
        end
        if (ctl.load_out)
        begin
            rv_reg      <= (cmd_reg == pidl_pkg::CMD_READ && st_reg == pidl_pkg::ST_DONE)
                           ? rdata_reg : '0;
            cnt_out_reg <= 8'(cnt_reg);
            st_out_reg  <= st_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = rv_reg;
    assign count      = cnt_out_reg;
    assign status     = st_out_reg;

endmodule
